@@ hdl/mesh_bounding_box_and_sphere_assert.svh @@
// assertion macros used by the checker file
`ifndef MESH_BOUNDING_BOX_AND_SPHERE_ASSERT_SVH
`define MESH_BOUNDING_BOX_AND_SPHERE_ASSERT_SVH

// property that holds at every edge outside reset
`define MBS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define MBS_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("implication failed");

`endif

@@ hdl/mbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbs_pkg
// types and constants shared by the bounding box and sphere block
// ----------------------------------------------------------------------------
package mbs_pkg;
  localparam int unsigned MaxVerticesDef = 1024;
  localparam int unsigned CoordWidthDef  = 16;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SCAN,
    BK_ROOT,
    BK_OUT
  } bk_state_t;
endpackage
`default_nettype wire

@@ hdl/mesh_bounding_box_and_sphere.sv @@
// order: after the last vertex is taken, a mesh of n stored vertices is read
//   from the store in one pass, then a 19-step root runs, then the result is registered
// throughput: one vertex per cycle while full is low; the next mesh waits until
//   the sphere pass has read the store, then loads during the root and hold
// reset: synchronous active-low rst_n clears counts, flags and state machines
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_bounding_box_and_sphere
// axis aligned box and center sphere of a streamed vertex mesh
// ----------------------------------------------------------------------------
module mesh_bounding_box_and_sphere import mbs_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef,
  parameter int unsigned COORD_WIDTH  = CoordWidthDef,
  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1),
  localparam int unsigned JW = 6 * COORD_WIDTH + CW + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output      logic                          full,
  input  wire logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  wire logic                          in_last,
  output      logic                          empty,
  input  wire logic                          pop,
  output      logic signed [COORD_WIDTH-1:0] out_min_x,
  output      logic signed [COORD_WIDTH-1:0] out_min_y,
  output      logic signed [COORD_WIDTH-1:0] out_min_z,
  output      logic signed [COORD_WIDTH-1:0] out_max_x,
  output      logic signed [COORD_WIDTH-1:0] out_max_y,
  output      logic signed [COORD_WIDTH-1:0] out_max_z,
  output      logic signed [COORD_WIDTH:0]   out_center_x_doubled,
  output      logic signed [COORD_WIDTH:0]   out_center_y_doubled,
  output      logic signed [COORD_WIDTH:0]   out_center_z_doubled,
  output      logic [COORD_WIDTH+1:0]        out_radius_doubled,
  output      logic                          out_overflowed
);
  logic wr_en, fjob_v, qjob_v, job_pop, q_full, store_busy;
  logic [AW-1:0] wr_addr;
  logic [3*COORD_WIDTH-1:0] wr_data;
  logic [JW-1:0] fjob, qjob_r;

  mbs_front #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst_n, .in_push(push), .in_full(full),
    .in_pos_x, .in_pos_y, .in_pos_z, .in_last,
    .wr_en, .wr_addr, .wr_data,
    .job_valid(fjob_v), .job_data(fjob), .job_full(q_full)
  );

  // one-entry job queue between loader and sphere pass
  always_ff @(posedge clk) begin
    if (!rst_n) qjob_v <= 1'b0;
    else if (fjob_v) qjob_v <= 1'b1;
    else if (job_pop) qjob_v <= 1'b0;
    if (fjob_v) qjob_r <= fjob;
  end
  // the store is shared, so loading halts until the pass has read it
  assign q_full = qjob_v || store_busy;

  mbs_back #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk, .rst_n, .wr_en, .wr_addr, .wr_data,
    .job_valid(qjob_v), .job_data(qjob_r), .job_pop, .store_busy,
    .out_empty(empty), .out_pop(pop),
    .out_min_x, .out_min_y, .out_min_z, .out_max_x, .out_max_y, .out_max_z,
    .out_center_x_doubled, .out_center_y_doubled, .out_center_z_doubled,
    .out_radius_doubled, .out_overflowed
  );
endmodule
`default_nettype wire

@@ hdl/mbs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbs_front
// accepts vertices, writes the store, tracks the running box
// ----------------------------------------------------------------------------
module mbs_front import mbs_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef,
  parameter int unsigned COORD_WIDTH  = CoordWidthDef,
  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1),
  localparam int unsigned JW = 6 * COORD_WIDTH + CW + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output      logic                          in_full,
  input  wire logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  wire logic                          in_last,
  output      logic                          wr_en,
  output      logic [AW-1:0]                 wr_addr,
  output      logic [3*COORD_WIDTH-1:0]      wr_data,
  output      logic                          job_valid,
  output      logic [JW-1:0]                 job_data,
  input  wire logic                          job_full
);
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic signed [COORD_WIDTH-1:0] mn_r [3];
  logic signed [COORD_WIDTH-1:0] mx_r [3];
  logic signed [COORD_WIDTH-1:0] mn_nxt [3];
  logic signed [COORD_WIDTH-1:0] mx_nxt [3];
  logic signed [COORD_WIDTH-1:0] p [3];
  logic room, acc;

  // every vertex, not only a mesh end, waits while the job queue is full or the store is busy
  assign in_full = job_full;
  assign acc     = in_push && !in_full;
  assign room    = count_r != CW'(MAX_VERTICES);
  assign p[0] = in_pos_x;
  assign p[1] = in_pos_y;
  assign p[2] = in_pos_z;

  assign wr_en   = acc && room;
  assign wr_addr = count_r[AW-1:0];
  assign wr_data = {in_pos_z, in_pos_y, in_pos_x};

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    for (int a = 0; a < 3; a++) begin
      mn_nxt[a] = mn_r[a];
      mx_nxt[a] = mx_r[a];
      if (wr_en && (count_r == '0 || p[a] < mn_r[a])) mn_nxt[a] = p[a];
      if (wr_en && (count_r == '0 || p[a] > mx_r[a])) mx_nxt[a] = p[a];
    end
    if (wr_en) count_nxt = count_r + CW'(1);
    if (acc && !room) ovf_nxt = 1'b1;
    // empty mesh reports a zero box
    if (count_nxt == '0) begin
      for (int a = 0; a < 3; a++) begin
        mn_nxt[a] = '0;
        mx_nxt[a] = '0;
      end
    end
  end

  assign job_valid = acc && in_last;
  assign job_data  = {ovf_nxt, count_nxt, mx_nxt[2], mx_nxt[1], mx_nxt[0],
                      mn_nxt[2], mn_nxt[1], mn_nxt[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (job_valid) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      mn_r[a] <= mn_nxt[a];
      mx_r[a] <= mx_nxt[a];
    end
  end
endmodule
`default_nettype wire

@@ hdl/mbs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbs_back
// sphere pass over the stored vertices, square root, result register
// ----------------------------------------------------------------------------
module mbs_back import mbs_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef,
  parameter int unsigned COORD_WIDTH  = CoordWidthDef,
  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1),
  localparam int unsigned JW = 6 * COORD_WIDTH + CW + 1,
  localparam int unsigned DW = COORD_WIDTH + 2,
  localparam int unsigned SW = 2 * DW + 2,
  localparam int unsigned RW = SW / 2,
  localparam int unsigned IW = $clog2(RW + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [3*COORD_WIDTH-1:0]      wr_data,
  input  wire logic                          job_valid,
  input  wire logic [JW-1:0]                 job_data,
  output      logic                          job_pop,
  output      logic                          store_busy,
  output      logic                          out_empty,
  input  wire logic                          out_pop,
  output      logic signed [COORD_WIDTH-1:0] out_min_x,
  output      logic signed [COORD_WIDTH-1:0] out_min_y,
  output      logic signed [COORD_WIDTH-1:0] out_min_z,
  output      logic signed [COORD_WIDTH-1:0] out_max_x,
  output      logic signed [COORD_WIDTH-1:0] out_max_y,
  output      logic signed [COORD_WIDTH-1:0] out_max_z,
  output      logic signed [COORD_WIDTH:0]   out_center_x_doubled,
  output      logic signed [COORD_WIDTH:0]   out_center_y_doubled,
  output      logic signed [COORD_WIDTH:0]   out_center_z_doubled,
  output      logic [COORD_WIDTH+1:0]        out_radius_doubled,
  output      logic                          out_overflowed
);
  logic [3*COORD_WIDTH-1:0] mem [MAX_VERTICES];
  logic [3*COORD_WIDTH-1:0] rd_r;

  bk_state_t st_r, st_nxt;
  logic [CW-1:0] idx_r, idx_nxt, n_r;
  logic [JW-1:0] job_r;
  logic signed [COORD_WIDTH:0] sum_r [3];
  logic [DW-2:0] mag_r [3];
  logic          mag_v_r, rd_v_r;
  logic [SW-1:0] best_r, rem_r;
  logic [RW-1:0] root_r;
  logic [IW-1:0] it_r;
  logic          full_r;
  logic signed [COORD_WIDTH-1:0] jmn [3];
  logic signed [COORD_WIDTH-1:0] jmx [3];
  logic [2*DW-3:0] sq [3];
  logic [SW-1:0] d2;
  logic          res_load;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_rd: rd_r <= mem[idx_r[AW-1:0]];
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      jmn[a] = job_r[a*COORD_WIDTH +: COORD_WIDTH];
      jmx[a] = job_r[(a+3)*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (job_valid) st_nxt = BK_READ;
      BK_READ: st_nxt = BK_SCAN;
      BK_SCAN: if (idx_r >= n_r && !rd_v_r && !mag_v_r) st_nxt = BK_ROOT;
      BK_ROOT: if (it_r == '0) st_nxt = BK_OUT;
      BK_OUT:  if (!full_r) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop    = (st_r == BK_IDLE) && job_valid;
    res_load   = (st_r == BK_OUT) && !full_r;
    store_busy = (st_r == BK_READ) || (st_r == BK_SCAN);
    idx_nxt    = idx_r;
    if (st_r == BK_SCAN && idx_r < n_r) idx_nxt = idx_r + CW'(1);
    if (st_r == BK_IDLE) idx_nxt = '0;
  end

  always_comb begin
    d2 = '0;
    for (int a = 0; a < 3; a++) begin
      sq[a] = mag_r[a] * mag_r[a];
      d2 = d2 + SW'(sq[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      full_r  <= 1'b0;
      rd_v_r  <= 1'b0;
      mag_v_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      idx_r   <= idx_nxt;
      rd_v_r  <= (st_r == BK_SCAN) && idx_r < n_r;
      mag_v_r <= rd_v_r;
      if (res_load) full_r <= 1'b1;
      else if (out_pop) full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r  <= job_data;
      n_r    <= job_data[6*COORD_WIDTH +: CW];
      best_r <= '0;
      for (int a = 0; a < 3; a++)
        sum_r[a] <= (COORD_WIDTH+1)'(signed'(job_data[a*COORD_WIDTH +: COORD_WIDTH]))
                  + (COORD_WIDTH+1)'(signed'(job_data[(a+3)*COORD_WIDTH +: COORD_WIDTH]));
    end
    if (rd_v_r) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [DW-1:0] d;
        d = DW'(signed'({rd_r[a*COORD_WIDTH +: COORD_WIDTH], 1'b0})) - DW'(sum_r[a]);
        mag_r[a] <= (DW-1)'(d < 0 ? -d : d);
      end
    end
    if (mag_v_r && d2 > best_r) best_r <= d2;
    // one result bit per cycle, restoring square root
    if (st_r == BK_SCAN && st_nxt == BK_ROOT) begin
      rem_r  <= mag_v_r && d2 > best_r ? d2 : best_r;
      root_r <= '0;
      it_r   <= IW'(RW);
    end else if (st_r == BK_ROOT && it_r != '0) begin
      logic [SW-1:0] t, r2;
      t  = {root_r, 2'b01} | SW'(0);
      r2 = rem_r >> (2 * (it_r - IW'(1)));
      if (r2 >= (t & ~SW'(0))) begin
        rem_r  <= rem_r - (t << (2 * (it_r - IW'(1))));
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        root_r <= {root_r[RW-2:0], 1'b0};
      end
      it_r <= it_r - IW'(1);
    end
    if (res_load) begin
      out_min_x <= jmn[0]; out_min_y <= jmn[1]; out_min_z <= jmn[2];
      out_max_x <= jmx[0]; out_max_y <= jmx[1]; out_max_z <= jmx[2];
      out_center_x_doubled <= sum_r[0];
      out_center_y_doubled <= sum_r[1];
      out_center_z_doubled <= sum_r[2];
      out_radius_doubled   <= (COORD_WIDTH+2)'(root_r);
      out_overflowed       <= job_r[JW-1];
    end
  end

  assign out_empty = !full_r;
endmodule
`default_nettype wire

@@ hdl/mbs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbs_checker
// port level checks on the result queue
// ----------------------------------------------------------------------------
`include "mesh_bounding_box_and_sphere_assert.svh"
module mbs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        push,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [17:0] out_radius_doubled
);
  `MBS_ASSERT_IMPL(held_result, !empty && !pop, !empty)
  `MBS_ASSERT_IMPL(stable_radius, !empty && !pop, $stable(out_radius_doubled))
  `MBS_ASSERT(empty_after_reset, $past(!rst_n) |-> empty)
endmodule

bind mesh_bounding_box_and_sphere mbs_checker u_mbs_checker (
  .clk, .rst_n, .push, .full, .empty, .pop,
  .out_radius_doubled(out_radius_doubled)
);
`default_nettype wire
